@@ src/lobm_pkg.sv @@
// shared types, codes and constants of the order book matcher
`default_nettype none
package lobm_pkg;

    localparam int LEVELS_DEF = 8;
    localparam int ORDERS_PER_LEVEL_DEF = 4;

    localparam int PW = 31;
    localparam int QW = 31;
    localparam int IDW = 32;
    localparam int LVL_W = 6;
    localparam int SLOT_W = 4;
    localparam int CAP_W = 7;
    localparam int FCNT_W = 6;
    localparam int FILLS_MAX = 63;
    localparam int CAP_RESET = 8;

    localparam logic [2:0] CMD_LIMIT  = 3'd0;
    localparam logic [2:0] CMD_CANCEL = 3'd1;
    localparam logic [2:0] CMD_MARKET = 3'd2;
    localparam logic [2:0] CMD_REDUCE = 3'd3;
    localparam logic [2:0] CMD_QUERY  = 3'd4;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_BAD_QTY    = 3'd1;
    localparam logic [2:0] STS_BAD_PRICE  = 3'd2;
    localparam logic [2:0] STS_NOT_FOUND  = 3'd3;
    localparam logic [2:0] STS_LEVEL_FULL = 3'd4;

    localparam logic CFG_LEVEL_CAP   = 1'b0;
    localparam logic CFG_FILL_REPORT = 1'b1;

    typedef enum logic [2:0] {
        SOP_NOP,
        SOP_SETQ,
        SOP_REMOVE,
        SOP_INSERT,
        SOP_APPEND,
        SOP_TRIM
    } t_side_op;

    typedef struct packed {
        t_side_op            op;
        logic [LVL_W-1:0]    lvl;
        logic [SLOT_W-1:0]   slot;
        logic [PW-1:0]       price;
        logic [IDW-1:0]      id;
        logic [QW-1:0]       qty;
        logic                strat;
        logic [CAP_W-1:0]    cap;
    } t_side_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MATCH,
        ST_REST,
        ST_TRIM,
        ST_FIND,
        ST_ACT,
        ST_QLVL,
        ST_QSUM,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic            kind;
        logic [IDW-1:0]  taker_id;
        logic [IDW-1:0]  maker_id;
        logic [PW-1:0]   fill_price;
        logic [QW-1:0]   fill_qty;
        logic [PW-1:0]   high_bid;
        logic            bid_valid;
        logic [PW-1:0]   low_ask;
        logic            ask_valid;
        logic [QW-1:0]   depth;
        logic [2:0]      status;
        logic            last;
    } t_result;

endpackage
`default_nettype wire

@@ src/lobm_if.sv @@
// command and result channel interfaces of the order book matcher
`default_nettype none
interface lobm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] order_id;
    logic [30:0] price;
    logic [30:0] qty;
    logic        side;
    logic        is_strategy;
    modport source (output valid, cmd, order_id, price, qty, side, is_strategy, input ready);
    modport sink (input valid, cmd, order_id, price, qty, side, is_strategy, output ready);
endinterface

interface lobm_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] taker_id;
    logic [31:0] maker_id;
    logic [30:0] fill_price;
    logic [30:0] fill_qty;
    logic [30:0] high_bid;
    logic        bid_valid;
    logic [30:0] low_ask;
    logic        ask_valid;
    logic [30:0] depth;
    logic [2:0]  status;
    logic        last;
    modport source (output valid, kind, taker_id, maker_id, fill_price, fill_qty, high_bid,
                    bid_valid, low_ask, ask_valid, depth, status, last, input ready);
    modport sink (input valid, kind, taker_id, maker_id, fill_price, fill_qty, high_bid,
                  bid_valid, low_ask, ask_valid, depth, status, last, output ready);
endinterface
`default_nettype wire

@@ src/lobm_side.sv @@
// one side of the book: sorted levels with order fifos and their update ops
`default_nettype none
module lobm_side #(
    parameter int LEVELS = 8,
    parameter int ORDERS_PER_LEVEL = 4
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  lobm_pkg::t_side_cmd                         i_cmd,
    output logic [30:0]                                 o_lp  [LEVELS],
    output logic [$clog2(ORDERS_PER_LEVEL+1)-1:0]       o_lf  [LEVELS],
    output logic [$clog2(LEVELS+1)-1:0]                 o_cnt,
    output logic [31:0]                                 o_oid [LEVELS][ORDERS_PER_LEVEL],
    output logic [30:0]                                 o_oq  [LEVELS][ORDERS_PER_LEVEL],
    output logic                                        o_os  [LEVELS][ORDERS_PER_LEVEL]
);
    import lobm_pkg::*;

    localparam int FW  = $clog2(ORDERS_PER_LEVEL + 1);
    localparam int CW  = $clog2(LEVELS + 1);
    localparam int LIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SIW = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;

    logic [PW-1:0]  r_lp  [LEVELS];
    logic [FW-1:0]  r_lf  [LEVELS];
    logic [FW-1:0]  n_lf  [LEVELS];
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic [IDW-1:0] r_oid [LEVELS][ORDERS_PER_LEVEL];
    logic [QW-1:0]  r_oq  [LEVELS][ORDERS_PER_LEVEL];
    logic           r_os  [LEVELS][ORDERS_PER_LEVEL];

    logic [LIW-1:0] lvl;
    logic [SIW-1:0] slot;
    logic [SIW-1:0] app;
    logic           gone;
    logic [CW-1:0]  ceff;
    logic [CW-1:0]  capv;

    assign lvl  = i_cmd.lvl[LIW-1:0];
    assign slot = i_cmd.slot[SIW-1:0];
    assign app  = r_lf[lvl][SIW-1:0];
    assign gone = (r_lf[lvl] == FW'(1));
    assign ceff = (r_cnt >= CW'(LEVELS)) ? CW'(LEVELS - 1) : r_cnt;
    assign capv = CW'(i_cmd.cap);

    always_comb begin
        n_lf  = r_lf;
        n_cnt = r_cnt;
        unique case (i_cmd.op)
            SOP_REMOVE: begin
                if (gone) begin
                    for (int i = 0; i < LEVELS; i++) begin
                        if (i >= int'(lvl)) begin
                            n_lf[i] = (i < LEVELS - 1) ? r_lf[(i < LEVELS - 1) ? i + 1 : i] : '0;
                        end
                    end
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    n_lf[lvl] = r_lf[lvl] - FW'(1);
                end
            end
            SOP_APPEND: n_lf[lvl] = r_lf[lvl] + FW'(1);
            SOP_INSERT: begin
                for (int i = 0; i < LEVELS; i++) begin
                    if (i > int'(lvl) && i <= int'(ceff)) begin
                        n_lf[i] = r_lf[(i > 0) ? i - 1 : i];
                    end
                end
                n_lf[lvl] = FW'(1);
                n_cnt = ceff + CW'(1);
            end
            SOP_TRIM: begin
                if (r_cnt > capv) begin
                    n_cnt = capv;
                    for (int i = 0; i < LEVELS; i++) begin
                        if (i >= int'(capv)) begin
                            n_lf[i] = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_lf[i] <= '0;
            end
        end else begin
            r_cnt <= n_cnt;
            r_lf  <= n_lf;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            SOP_SETQ: r_oq[lvl][slot] <= i_cmd.qty;
            SOP_REMOVE: begin
                if (gone) begin
                    for (int i = 0; i < LEVELS - 1; i++) begin
                        if (i >= int'(lvl)) begin
                            r_lp[i] <= r_lp[i + 1];
                            for (int j = 0; j < ORDERS_PER_LEVEL; j++) begin
                                r_oid[i][j] <= r_oid[i + 1][j];
                                r_oq[i][j]  <= r_oq[i + 1][j];
                                r_os[i][j]  <= r_os[i + 1][j];
                            end
                        end
                    end
                end else begin
                    for (int j = 0; j < ORDERS_PER_LEVEL - 1; j++) begin
                        if (j >= int'(slot)) begin
                            r_oid[lvl][j] <= r_oid[lvl][j + 1];
                            r_oq[lvl][j]  <= r_oq[lvl][j + 1];
                            r_os[lvl][j]  <= r_os[lvl][j + 1];
                        end
                    end
                end
            end
            SOP_APPEND: begin
                r_oid[lvl][app] <= i_cmd.id;
                r_oq[lvl][app]  <= i_cmd.qty;
                r_os[lvl][app]  <= i_cmd.strat;
            end
            SOP_INSERT: begin
                for (int i = 1; i < LEVELS; i++) begin
                    if (i > int'(lvl) && i <= int'(ceff)) begin
                        r_lp[i] <= r_lp[i - 1];
                        for (int j = 0; j < ORDERS_PER_LEVEL; j++) begin
                            r_oid[i][j] <= r_oid[i - 1][j];
                            r_oq[i][j]  <= r_oq[i - 1][j];
                            r_os[i][j]  <= r_os[i - 1][j];
                        end
                    end
                end
                r_lp[lvl]     <= i_cmd.price;
                r_oid[lvl][0] <= i_cmd.id;
                r_oq[lvl][0]  <= i_cmd.qty;
                r_os[lvl][0]  <= i_cmd.strat;
            end
            default: ;
        endcase
    end

    assign o_lp  = r_lp;
    assign o_lf  = r_lf;
    assign o_cnt = r_cnt;
    assign o_oid = r_oid;
    assign o_oq  = r_oq;
    assign o_os  = r_os;

endmodule
`default_nettype wire

@@ src/limit_order_book_matcher.sv @@
// top level: command sequencer, shared compare/subtract unit and result register
//
//  channel  | dir | handshake          | word
//  i_in     | in  | valid/ready        | cmd, order_id, price, qty, side, is_strategy
//  o_out    | out | valid/ready        | kind, ids, fill price/qty, best bid/ask, depth, status
//  cfg      | in  | i_cfg_we           | i_cfg_idx selects level_cap or fill_report_enable
//
//  one command at a time: it is accepted, decoded and completed; a match steps through
//  its fills and then ends, a limit that rests scans the levels for its place, cancel
//  and reduce search each side in turn, a query finds its level and sums its orders,
//  and a limit then trims both sides; a rejected command goes from decode to done
//  reset clears level counts and fill counts; order payload stores are not cleared
//  a full result register stalls the sequencer when it has a word to write, until the word is taken
`default_nettype none
module limit_order_book_matcher #(
    parameter int LEVELS = lobm_pkg::LEVELS_DEF,
    parameter int ORDERS_PER_LEVEL = lobm_pkg::ORDERS_PER_LEVEL_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lobm_in_if.sink     i_in,
    lobm_out_if.source  o_out,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_idx,
    input  wire logic [3:0] i_cfg_wdata
);
    import lobm_pkg::*;

    localparam int FW  = $clog2(ORDERS_PER_LEVEL + 1);
    localparam int CW  = $clog2(LEVELS + 1);
    localparam int LIW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SIW = (ORDERS_PER_LEVEL > 1) ? $clog2(ORDERS_PER_LEVEL) : 1;

    logic [PW-1:0]  b_lp  [LEVELS];
    logic [FW-1:0]  b_lf  [LEVELS];
    logic [CW-1:0]  b_cnt;
    logic [IDW-1:0] b_oid [LEVELS][ORDERS_PER_LEVEL];
    logic [QW-1:0]  b_oq  [LEVELS][ORDERS_PER_LEVEL];
    logic           b_os  [LEVELS][ORDERS_PER_LEVEL];
    logic [PW-1:0]  a_lp  [LEVELS];
    logic [FW-1:0]  a_lf  [LEVELS];
    logic [CW-1:0]  a_cnt;
    logic [IDW-1:0] a_oid [LEVELS][ORDERS_PER_LEVEL];
    logic [QW-1:0]  a_oq  [LEVELS][ORDERS_PER_LEVEL];
    logic           a_os  [LEVELS][ORDERS_PER_LEVEL];

    t_side_cmd bid_cmd;
    t_side_cmd ask_cmd;
    t_side_cmd s_cmd;
    logic      trim_both;

    lobm_side #(.LEVELS(LEVELS), .ORDERS_PER_LEVEL(ORDERS_PER_LEVEL)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(bid_cmd),
        .o_lp(b_lp), .o_lf(b_lf), .o_cnt(b_cnt), .o_oid(b_oid), .o_oq(b_oq), .o_os(b_os)
    );

    lobm_side #(.LEVELS(LEVELS), .ORDERS_PER_LEVEL(ORDERS_PER_LEVEL)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(ask_cmd),
        .o_lp(a_lp), .o_lf(a_lf), .o_cnt(a_cnt), .o_oid(a_oid), .o_oq(a_oq), .o_os(a_os)
    );

    t_state          r_state, n_state;
    logic [2:0]      r_cmd;
    logic [IDW-1:0]  r_id;
    logic [PW-1:0]   r_price;
    logic [QW-1:0]   r_qty;
    logic            r_side;
    logic            r_strat;
    logic [QW-1:0]   r_rem, n_rem;
    logic [2:0]      r_status, n_status;
    logic [CW-1:0]   r_lvl, n_lvl;
    logic [FW-1:0]   r_slot, n_slot;
    logic            r_fside, n_fside;
    logic [CW-1:0]   r_pos, n_pos;
    logic [FCNT_W-1:0] r_fills, n_fills;
    logic [QW-1:0]   r_acc, n_acc;
    t_result         r_res, n_res;
    logic            r_ov, n_ov;
    logic [3:0]      r_cap;
    logic            r_fre;

    logic            in_fire;
    logic            out_free;
    logic            v_side;
    logic [PW-1:0]   v_lp  [LEVELS];
    logic [FW-1:0]   v_lf  [LEVELS];
    logic [CW-1:0]   v_cnt;
    logic [IDW-1:0]  v_oid [LEVELS][ORDERS_PER_LEVEL];
    logic [QW-1:0]   v_oq  [LEVELS][ORDERS_PER_LEVEL];
    logic            v_os  [LEVELS][ORDERS_PER_LEVEL];
    logic [LIW-1:0]  li;
    logic [SIW-1:0]  si;
    logic [PW-1:0]   cur_lp;
    logic [FW-1:0]   cur_lf;
    logic [IDW-1:0]  cur_oid;
    logic [QW-1:0]   cur_oq;
    logic            cur_os;
    logic            lvl_end;
    logic            hit_any;
    logic [SIW-1:0]  hit_idx;
    logic [QW-1:0]   u_a, u_b, u_min, u_diff;
    logic            u_lt;
    logic [QW:0]     sum;
    logic [CAP_W-1:0] cap_x;
    logic [CW-1:0]   ecap;
    logic            report;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 4'(CAP_RESET);
            r_fre <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEVEL_CAP:   r_cap <= i_cfg_wdata;
                CFG_FILL_REPORT: r_fre <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_cap == 4'd0) begin
            cap_x = CAP_W'(1);
        end else if (CAP_W'(r_cap) > CAP_W'(LEVELS)) begin
            cap_x = CAP_W'(LEVELS);
        end else begin
            cap_x = CAP_W'(r_cap);
        end
    end
    assign ecap = CW'(cap_x);

    always_comb begin
        unique case (r_state) inside
            ST_MATCH:       v_side = ~r_side;
            ST_FIND, ST_ACT: v_side = r_fside;
            default:        v_side = r_side;
        endcase
    end

    always_comb begin
        v_cnt = v_side ? a_cnt : b_cnt;
        for (int i = 0; i < LEVELS; i++) begin
            v_lp[i] = v_side ? a_lp[i] : b_lp[i];
            v_lf[i] = v_side ? a_lf[i] : b_lf[i];
            for (int j = 0; j < ORDERS_PER_LEVEL; j++) begin
                v_oid[i][j] = v_side ? a_oid[i][j] : b_oid[i][j];
                v_oq[i][j]  = v_side ? a_oq[i][j]  : b_oq[i][j];
                v_os[i][j]  = v_side ? a_os[i][j]  : b_os[i][j];
            end
        end
    end

    assign li      = r_lvl[LIW-1:0];
    assign si      = r_slot[SIW-1:0];
    assign cur_lp  = v_lp[li];
    assign cur_lf  = v_lf[li];
    assign cur_oid = v_oid[li][si];
    assign cur_oq  = v_oq[li][si];
    assign cur_os  = v_os[li][si];
    assign lvl_end = (r_lvl >= v_cnt);

    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int j = ORDERS_PER_LEVEL - 1; j >= 0; j--) begin
            if (FW'(j) < cur_lf && v_oid[li][j] == r_id) begin
                hit_any = 1'b1;
                hit_idx = SIW'(j);
            end
        end
    end

    // shared compare and subtract
    assign u_a    = (r_state == ST_ACT) ? r_qty : r_rem;
    assign u_b    = cur_oq;
    assign u_lt   = (u_a < u_b);
    assign u_min  = u_lt ? u_a : u_b;
    assign u_diff = u_lt ? (u_b - u_a) : (u_a - u_b);

    assign sum = {1'b0, r_acc} + {1'b0, cur_oq};

    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_status  = r_status;
        n_lvl     = r_lvl;
        n_slot    = r_slot;
        n_fside   = r_fside;
        n_pos     = r_pos;
        n_fills   = r_fills;
        n_acc     = r_acc;
        n_res     = r_res;
        n_ov      = r_ov && !o_out.ready;
        s_cmd     = '0;
        s_cmd.op  = SOP_NOP;
        s_cmd.lvl = LVL_W'(r_lvl);
        s_cmd.slot = SLOT_W'(r_slot);
        s_cmd.price = r_price;
        s_cmd.id  = r_id;
        s_cmd.qty = r_qty;
        s_cmd.strat = r_strat;
        s_cmd.cap = cap_x;
        trim_both = 1'b0;
        report    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state  = ST_DECODE;
                    n_status = STS_OK;
                    n_acc    = '0;
                    n_fills  = '0;
                    n_lvl    = '0;
                    n_slot   = '0;
                    n_fside  = 1'b0;
                    n_pos    = '0;
                end
            end
            ST_DECODE: begin
                n_rem = r_qty;
                unique case (r_cmd)
                    CMD_LIMIT: begin
                        if (r_qty == '0) begin
                            n_status = STS_BAD_QTY;
                            n_state  = ST_DONE;
                        end else if (r_price == '0) begin
                            n_status = STS_BAD_PRICE;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_MATCH;
                        end
                    end
                    CMD_MARKET: begin
                        if (r_qty == '0) begin
                            n_status = STS_BAD_QTY;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_MATCH;
                        end
                    end
                    CMD_CANCEL: n_state = ST_FIND;
                    CMD_REDUCE: begin
                        if (r_qty == '0) begin
                            n_status = STS_BAD_QTY;
                            n_state  = ST_DONE;
                        end else begin
                            n_state = ST_FIND;
                        end
                    end
                    CMD_QUERY: n_state = ST_QLVL;
                    default:   n_state = ST_DONE;
                endcase
            end
            ST_MATCH: begin
                if (r_rem == '0 || v_cnt == '0 || (r_cmd == CMD_LIMIT &&
                    (r_side ? (r_price > cur_lp) : (r_price < cur_lp)))) begin
                    if (r_cmd != CMD_LIMIT) begin
                        n_state = ST_DONE;
                    end else if (r_rem != '0) begin
                        n_state = ST_REST;
                    end else begin
                        n_state = ST_TRIM;
                    end
                end else begin
                    report = (r_cmd == CMD_MARKET) || (cur_os && r_fre);
                    if (report && r_fills < FCNT_W'(FILLS_MAX) && !out_free) begin
                        n_state = ST_MATCH;
                    end else begin
                        if (report && r_fills < FCNT_W'(FILLS_MAX)) begin
                            n_ov  = 1'b1;
                            n_res = '0;
                            n_res.taker_id   = (r_cmd == CMD_MARKET) ? '0 : r_id;
                            n_res.maker_id   = cur_oid;
                            n_res.fill_price = cur_lp;
                            n_res.fill_qty   = u_min;
                            n_fills = r_fills + FCNT_W'(1);
                        end
                        n_rem = u_lt ? '0 : u_diff;
                        if (u_lt) begin
                            s_cmd.op  = SOP_SETQ;
                            s_cmd.qty = u_diff;
                        end else begin
                            s_cmd.op = SOP_REMOVE;
                        end
                    end
                end
            end
            ST_REST: begin
                if (lvl_end) begin
                    if (r_pos < ecap) begin
                        s_cmd.op  = SOP_INSERT;
                        s_cmd.lvl = LVL_W'(r_pos);
                        s_cmd.qty = r_rem;
                    end
                    n_state = ST_TRIM;
                end else if (cur_lp == r_price) begin
                    if (cur_lf >= FW'(ORDERS_PER_LEVEL)) begin
                        n_status = STS_LEVEL_FULL;
                    end else begin
                        s_cmd.op  = SOP_APPEND;
                        s_cmd.qty = r_rem;
                    end
                    n_state = ST_TRIM;
                end else begin
                    if (r_side ? (cur_lp < r_price) : (cur_lp > r_price)) begin
                        n_pos = r_lvl + CW'(1);
                    end
                    n_lvl = r_lvl + CW'(1);
                end
            end
            ST_TRIM: begin
                s_cmd.op  = SOP_TRIM;
                trim_both = 1'b1;
                n_state   = ST_DONE;
            end
            ST_FIND: begin
                if (lvl_end) begin
                    n_lvl = '0;
                    if (!r_fside) begin
                        n_fside = 1'b1;
                    end else begin
                        n_status = STS_NOT_FOUND;
                        n_state  = ST_DONE;
                    end
                end else if (hit_any) begin
                    n_slot  = FW'(hit_idx);
                    n_state = ST_ACT;
                end else begin
                    n_lvl = r_lvl + CW'(1);
                end
            end
            ST_ACT: begin
                report = (r_cmd == CMD_REDUCE) && cur_os && r_fre;
                if (report && !out_free) begin
                    n_state = ST_ACT;
                end else begin
                    if (report) begin
                        n_ov  = 1'b1;
                        n_res = '0;
                        n_res.maker_id   = cur_oid;
                        n_res.fill_price = cur_lp;
                        n_res.fill_qty   = u_min;
                    end
                    if (r_cmd == CMD_REDUCE && u_lt) begin
                        s_cmd.op  = SOP_SETQ;
                        s_cmd.qty = u_diff;
                    end else begin
                        s_cmd.op = SOP_REMOVE;
                    end
                    n_state = ST_DONE;
                end
            end
            ST_QLVL: begin
                if (lvl_end) begin
                    n_state = ST_DONE;
                end else if (cur_lp == r_price) begin
                    n_slot  = '0;
                    n_state = ST_QSUM;
                end else begin
                    n_lvl = r_lvl + CW'(1);
                end
            end
            ST_QSUM: begin
                if (r_slot >= cur_lf) begin
                    n_state = ST_DONE;
                end else begin
                    n_acc  = sum[QW] ? {QW{1'b1}} : sum[QW-1:0];
                    n_slot = r_slot + FW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_res = '0;
                    n_res.kind      = 1'b1;
                    n_res.bid_valid = (b_cnt != '0);
                    n_res.high_bid  = (b_cnt != '0) ? b_lp[0] : '0;
                    n_res.ask_valid = (a_cnt != '0);
                    n_res.low_ask   = (a_cnt != '0) ? a_lp[0] : '0;
                    n_res.depth     = r_acc;
                    n_res.status    = r_status;
                    n_res.last      = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        bid_cmd = '0;
        ask_cmd = '0;
        if (trim_both || !v_side) begin
            bid_cmd = s_cmd;
        end
        if (trim_both || v_side) begin
            ask_cmd = s_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd   <= i_in.cmd;
            r_id    <= i_in.order_id;
            r_price <= i_in.price;
            r_qty   <= i_in.qty;
            r_side  <= i_in.side;
            r_strat <= i_in.is_strategy;
        end
        r_rem    <= n_rem;
        r_status <= n_status;
        r_lvl    <= n_lvl;
        r_slot   <= n_slot;
        r_fside  <= n_fside;
        r_pos    <= n_pos;
        r_fills  <= n_fills;
        r_acc    <= n_acc;
        r_res    <= n_res;
    end

    assign o_out.valid      = r_ov;
    assign o_out.kind       = r_res.kind;
    assign o_out.taker_id   = r_res.taker_id;
    assign o_out.maker_id   = r_res.maker_id;
    assign o_out.fill_price = r_res.fill_price;
    assign o_out.fill_qty   = r_res.fill_qty;
    assign o_out.high_bid   = r_res.high_bid;
    assign o_out.bid_valid  = r_res.bid_valid;
    assign o_out.low_ask    = r_res.low_ask;
    assign o_out.ask_valid  = r_res.ask_valid;
    assign o_out.depth      = r_res.depth;
    assign o_out.status     = r_res.status;
    assign o_out.last       = r_res.last;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_cnt <= CW'(LEVELS)) && (a_cnt <= CW'(LEVELS)))
        else $error("level count beyond storage");
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((b_cnt != '0) || (b_lf[0] == '0)) && ((a_cnt != '0) || (a_lf[0] == '0)))
        else $error("empty side holds a nonzero level fill");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in.ready)
        else $error("new command taken while one is in progress");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_ov && r_res.last && r_state == ST_IDLE))
        else $error("completion not issued on leaving done");
`endif

endmodule
`default_nettype wire

@@ test/lobm_tb_if.sv @@
// testbench-side reference of the channel interfaces (kept in the test folder); nothing defined here
`default_nettype none
`default_nettype wire

@@ test/testbench.sv @@
// testbench for the order book matcher: random and directed commands against a book predictor
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lobm_pkg::*;

    localparam int NLVL = 8;
    localparam int NORD = 4;
    localparam int QMAX = 32'h7fffffff;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] order_id;
        logic [30:0] price;
        logic [30:0] qty;
        logic        side;
        logic        is_strategy;
    } t_cmd_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [3:0] i_cfg_wdata = 4'd0;

    lobm_in_if in_ch();
    lobm_out_if out_ch();

    limit_order_book_matcher dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // book mirror: [side][level], [side][level*NORD+k]
    logic [30:0] lvl_price [2][NLVL];
    int          lvl_fill  [2][NLVL];
    int          lvl_cnt   [2];
    logic [31:0] ord_id    [2][NLVL*NORD];
    logic [30:0] ord_qty   [2][NLVL*NORD];
    logic        ord_strat [2][NLVL*NORD];
    logic [3:0]  cap_reg = 4'd8;
    logic        report_en = 1'b0;

    t_result    expected_words[$];
    t_cmd_word  pending_cmds[$];
    int         fails = 0;
    int         nfill;
    bit         calm = 1'b0;
    bit         drain_done = 1'b0;

    function automatic int eff_cap();
        if (cap_reg == 0) return 1;
        return (cap_reg > NLVL) ? NLVL : int'(cap_reg);
    endfunction

    task automatic add_expect(t_result r);
        expected_words.insert(expected_words.size(), r);
    endtask

    task automatic queue_cmd(t_cmd_word c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic push_fill(logic [31:0] tk, logic [31:0] mk, logic [30:0] p, logic [30:0] q);
        t_result r;
        r = '0;
        if (nfill >= FILLS_MAX) return;
        r.taker_id = tk; r.maker_id = mk; r.fill_price = p; r.fill_qty = q;
        add_expect(r);
        nfill++;
    endtask

    task automatic move_slot(int s, int d, int src);
        ord_id[s][d] = ord_id[s][src];
        ord_qty[s][d] = ord_qty[s][src];
        ord_strat[s][d] = ord_strat[s][src];
    endtask

    task automatic move_level(int s, int d, int src);
        lvl_price[s][d] = lvl_price[s][src];
        lvl_fill[s][d] = lvl_fill[s][src];
        for (int k = 0; k < NORD; k++) move_slot(s, d*NORD+k, src*NORD+k);
    endtask

    task automatic drop_level(int s, int l);
        if (l >= lvl_cnt[s]) return;
        for (int i = l; i + 1 < lvl_cnt[s]; i++) move_level(s, i, i+1);
        lvl_cnt[s]--;
        lvl_fill[s][lvl_cnt[s]] = 0;
    endtask

    task automatic drop_order(int s, int l, int k);
        for (int j = k; j + 1 < lvl_fill[s][l]; j++) move_slot(s, l*NORD+j, l*NORD+j+1);
        lvl_fill[s][l]--;
        if (lvl_fill[s][l] == 0) drop_level(s, l);
    endtask

    task automatic trade(input int s, input bit limited, input logic [30:0] p,
                         inout logic [30:0] q, input logic [31:0] tk, input bit always_rep);
        int o;
        logic [30:0] lp, rq, tr;
        o = 1 - s;
        while (q > 0 && lvl_cnt[o] > 0) begin
            lp = lvl_price[o][0];
            rq = ord_qty[o][0];
            if (limited && (s == 0 ? p < lp : p > lp)) break;
            tr = (q < rq) ? q : rq;
            rq -= tr;
            q -= tr;
            if (always_rep || (ord_strat[o][0] && report_en))
                push_fill(tk, ord_id[o][0], lp, tr);
            if (rq == 0) drop_order(o, 0, 0);
            else ord_qty[o][0] = rq;
        end
    endtask

    function automatic bit locate(logic [31:0] id, output int s, output int l, output int k);
        for (int sd = 0; sd < 2; sd++)
            for (int li = 0; li < lvl_cnt[sd]; li++)
                for (int j = 0; j < lvl_fill[sd][li]; j++)
                    if (ord_id[sd][li*NORD+j] == id) begin
                        s = sd; l = li; k = j;
                        return 1'b1;
                    end
        return 1'b0;
    endfunction

    task automatic rest(int s, t_cmd_word c, logic [30:0] q, output logic [2:0] st);
        int pos, slot;
        pos = 0;
        st = STS_OK;
        for (int l = 0; l < lvl_cnt[s]; l++) begin
            if (lvl_price[s][l] == c.price) begin
                if (lvl_fill[s][l] >= NORD) begin
                    st = STS_LEVEL_FULL;
                    return;
                end
                slot = l*NORD + lvl_fill[s][l];
                ord_id[s][slot] = c.order_id; ord_qty[s][slot] = q;
                ord_strat[s][slot] = c.is_strategy;
                lvl_fill[s][l]++;
                return;
            end
            if (s == 0 ? lvl_price[s][l] > c.price : lvl_price[s][l] < c.price) pos = l + 1;
        end
        if (pos >= eff_cap()) return;
        if (lvl_cnt[s] >= NLVL) lvl_cnt[s] = NLVL - 1;
        for (int l = lvl_cnt[s]; l > pos; l--) move_level(s, l, l-1);
        lvl_price[s][pos] = c.price;
        lvl_fill[s][pos] = 1;
        ord_id[s][pos*NORD] = c.order_id; ord_qty[s][pos*NORD] = q;
        ord_strat[s][pos*NORD] = c.is_strategy;
        lvl_cnt[s]++;
    endtask

    task automatic predict_book(t_cmd_word c);
        t_result r;
        logic [2:0] st;
        logic [30:0] q, oq;
        logic [32:0] dsum;
        int s, l, k, sd;
        st = STS_OK;
        dsum = '0;
        nfill = 0;
        sd = int'(c.side);
        q = c.qty;
        case (c.cmd)
            CMD_LIMIT: begin
                if (c.qty == 0) st = STS_BAD_QTY;
                else if (c.price == 0) st = STS_BAD_PRICE;
                else begin
                    trade(sd, 1'b1, c.price, q, c.order_id, 1'b0);
                    if (q > 0) rest(sd, c, q, st);
                    for (int sx = 0; sx < 2; sx++)
                        while (lvl_cnt[sx] > eff_cap()) begin
                            lvl_cnt[sx]--;
                            lvl_fill[sx][lvl_cnt[sx]] = 0;
                        end
                end
            end
            CMD_CANCEL: begin
                if (locate(c.order_id, s, l, k)) drop_order(s, l, k);
                else st = STS_NOT_FOUND;
            end
            CMD_MARKET: begin
                if (c.qty == 0) st = STS_BAD_QTY;
                else trade(sd, 1'b0, '0, q, '0, 1'b1);
            end
            CMD_REDUCE: begin
                if (c.qty == 0) st = STS_BAD_QTY;
                else if (locate(c.order_id, s, l, k)) begin
                    oq = ord_qty[s][l*NORD+k];
                    if (ord_strat[s][l*NORD+k] && report_en)
                        push_fill('0, ord_id[s][l*NORD+k], lvl_price[s][l],
                                  (c.qty < oq) ? c.qty : oq);
                    if (c.qty >= oq) drop_order(s, l, k);
                    else ord_qty[s][l*NORD+k] = oq - c.qty;
                end else st = STS_NOT_FOUND;
            end
            CMD_QUERY: begin
                for (int li = 0; li < lvl_cnt[sd]; li++)
                    if (lvl_price[sd][li] == c.price) begin
                        for (int j = 0; j < lvl_fill[sd][li]; j++)
                            dsum += ord_qty[sd][li*NORD+j];
                        break;
                    end
                if (dsum > QMAX) dsum = QMAX;
            end
            default: ;
        endcase
        r = '0;
        r.kind = 1'b1;
        if (lvl_cnt[0] > 0) begin r.high_bid = lvl_price[0][0]; r.bid_valid = 1'b1; end
        if (lvl_cnt[1] > 0) begin r.low_ask = lvl_price[1][0]; r.ask_valid = 1'b1; end
        r.depth = dsum[30:0];
        r.status = st;
        r.last = 1'b1;
        add_expect(r);
    endtask

    // driver
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_book(pending_cmds[0]);
                pending_cmds.delete(0);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    {in_ch.cmd, in_ch.order_id, in_ch.price, in_ch.qty, in_ch.side,
                     in_ch.is_strategy} <= pending_cmds[0];
                    if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 15);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int hold = 0;
    t_result got, want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.kind, out_ch.taker_id, out_ch.maker_id, out_ch.fill_price,
                        out_ch.fill_qty, out_ch.high_bid, out_ch.bid_valid, out_ch.low_ask,
                        out_ch.ask_valid, out_ch.depth, out_ch.status, out_ch.last};
                if (expected_words.size() == 0) begin
                    $error("unexpected word %p", got);
                    fails++;
                end else begin
                    want = expected_words[0];
                    expected_words.delete(0);
                    if (got.kind != want.kind) begin
                        $error("kind exp %0d got %0d", want.kind, got.kind); fails++;
                    end
                    if (got.taker_id != want.taker_id) begin
                        $error("taker_id exp %0d got %0d", want.taker_id, got.taker_id);
                        fails++;
                    end
                    if (got.maker_id != want.maker_id) begin
                        $error("maker_id exp %0d got %0d", want.maker_id, got.maker_id);
                        fails++;
                    end
                    if (got.fill_price != want.fill_price) begin
                        $error("fill_price exp %0d got %0d", want.fill_price, got.fill_price);
                        fails++;
                    end
                    if (got.fill_qty != want.fill_qty) begin
                        $error("fill_qty exp %0d got %0d", want.fill_qty, got.fill_qty);
                        fails++;
                    end
                    if (got.high_bid != want.high_bid) begin
                        $error("high_bid exp %0d got %0d", want.high_bid, got.high_bid);
                        fails++;
                    end
                    if (got.bid_valid != want.bid_valid) begin
                        $error("bid_valid exp %0d got %0d", want.bid_valid, got.bid_valid);
                        fails++;
                    end
                    if (got.low_ask != want.low_ask) begin
                        $error("low_ask exp %0d got %0d", want.low_ask, got.low_ask);
                        fails++;
                    end
                    if (got.ask_valid != want.ask_valid) begin
                        $error("ask_valid exp %0d got %0d", want.ask_valid, got.ask_valid);
                        fails++;
                    end
                    if (got.depth != want.depth) begin
                        $error("depth exp %0d got %0d", want.depth, got.depth); fails++;
                    end
                    if (got.status != want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status); fails++;
                    end
                    if (got.last != want.last) begin
                        $error("last exp %0d got %0d", want.last, got.last); fails++;
                    end
                end
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 15);
            end
        end
    end

    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_cmd_word mk(logic [2:0] c, logic [31:0] id, logic [30:0] p,
                                     logic [30:0] q, logic sd, logic st);
        return '{c, id, p, q, sd, st};
    endfunction

    function automatic t_cmd_word rand_cmd(logic [31:0] base_id);
        t_cmd_word c;
        int pick;
        pick = $urandom_range(0, 99);
        c.side = 1'($urandom_range(0, 1));
        c.is_strategy = 1'($urandom_range(0, 1));
        c.price = 31'(100 + $urandom_range(0, 12));
        c.qty = 31'($urandom_range(1, 40));
        c.order_id = base_id + $urandom_range(0, 30);
        if (pick < 50) c.cmd = CMD_LIMIT;
        else if (pick < 62) c.cmd = CMD_CANCEL;
        else if (pick < 72) c.cmd = CMD_MARKET;
        else if (pick < 84) c.cmd = CMD_REDUCE;
        else if (pick < 94) c.cmd = CMD_QUERY;
        else begin
            // noise: wide fields, zero fields, unused codes
            c.cmd = 3'($urandom_range(0, 7));
            c.order_id = $urandom;
            c.price = ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom);
            c.qty = ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom);
        end
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || in_ch.valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LEVEL_CAP) cap_reg = v;
        else report_en = v[0];
        @(posedge i_clk);
    endtask

    initial begin
        logic [3:0] caps [4];
        in_ch.valid = 1'b0;
        in_ch.cmd = '0; in_ch.order_id = '0; in_ch.price = '0; in_ch.qty = '0;
        in_ch.side = 1'b0; in_ch.is_strategy = 1'b0;
        out_ch.ready = 1'b0;
        for (int s = 0; s < 2; s++) begin
            lvl_cnt[s] = 0;
            for (int l = 0; l < NLVL; l++) lvl_fill[s][l] = 0;
        end
        caps = '{4'd1, 4'd15, 4'd3, 4'd0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(CFG_FILL_REPORT, 4'd1);

        // directed
        queue_cmd(mk(CMD_LIMIT, 32'd1, 31'd100, 31'd0, 1'b0, 1'b0));
        queue_cmd(mk(CMD_LIMIT, 32'd1, 31'd0, 31'd5, 1'b0, 1'b0));
        queue_cmd(mk(CMD_MARKET, 32'd1, 31'd0, 31'd0, 1'b0, 1'b0));
        queue_cmd(mk(CMD_REDUCE, 32'd1, 31'd0, 31'd0, 1'b0, 1'b0));
        queue_cmd(mk(CMD_CANCEL, 32'hffffffff, 31'd0, 31'd0, 1'b0, 1'b0));
        queue_cmd(mk(CMD_REDUCE, 32'hffffffff, 31'd0, 31'd3, 1'b1, 1'b0));
        for (int i = 0; i < 5; i++)
            queue_cmd(mk(CMD_LIMIT, 32'd10+i, 31'h7fffffff, 31'h7fffffff, 1'b1, 1'b1));
        queue_cmd(mk(CMD_QUERY, 32'd0, 31'h7fffffff, 31'd0, 1'b1, 1'b0));
        queue_cmd(mk(CMD_LIMIT, 32'hffffffff, 31'd50, 31'd7, 1'b0, 1'b1));
        queue_cmd(mk(CMD_LIMIT, 32'hffffffff, 31'd50, 31'd9, 1'b0, 1'b0));
        queue_cmd(mk(CMD_REDUCE, 32'hffffffff, 31'd0, 31'd3, 1'b0, 1'b0));
        queue_cmd(mk(CMD_REDUCE, 32'hffffffff, 31'd0, 31'd99, 1'b0, 1'b0));
        queue_cmd(mk(CMD_LIMIT, 32'd20, 31'h7fffffff, 31'd2, 1'b0, 1'b0));
        queue_cmd(mk(CMD_MARKET, 32'd0, 31'd0, 31'h7fffffff, 1'b0, 1'b0));
        queue_cmd(mk(CMD_MARKET, 32'd0, 31'd0, 31'h7fffffff, 1'b1, 1'b0));
        queue_cmd(mk(3'd5, 32'd0, 31'd0, 31'd0, 1'b0, 1'b0));
        queue_cmd(mk(3'd7, 32'hffffffff, 31'h7fffffff, 31'h7fffffff, 1'b1, 1'b1));
        queue_cmd(mk(CMD_CANCEL, 32'd20, 31'd0, 31'd0, 1'b0, 1'b0));
        wait_drained();

        // random phases across register settings
        for (int ph = 0; ph < 5; ph++) begin
            if (ph < 4) write_reg(CFG_LEVEL_CAP, caps[ph]);
            else write_reg(CFG_LEVEL_CAP, 4'd8);
            write_reg(CFG_FILL_REPORT, 4'($urandom_range(0, 1)));
            if (ph == 4) calm = 1'b1;
            for (int i = 0; i < 62; i++) queue_cmd(rand_cmd(32'd1000 + ph*40));
            wait_drained();
        end
        drain_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (drain_done) begin
            if (fails == 0) $display("Simulation PASSED");
            else $display("Simulation FAILED");
            $finish;
        end
    end
endmodule
`default_nettype wire

@@ limit_order_book_matcher.f @@
src/lobm_pkg.sv
src/lobm_if.sv
src/lobm_side.sv
src/limit_order_book_matcher.sv
test/lobm_tb_if.sv
test/testbench.sv
